### hw/rtl/eprm_pkg.sv
package eprm_pkg;

  localparam int CordicIterations = 16;
  localparam int AtanEntries      = 24;
  localparam int NumStages = (CordicIterations < AtanEntries) ? CordicIterations : AtanEntries;
  localparam int AngW = 28;

  localparam logic signed [AngW-1:0] PiQ24     = 28'sd52707179;
  localparam logic signed [AngW-1:0] HalfPiQ24 = 28'sd26353589;
  localparam logic signed [AngW-1:0] GainQ24   = 28'sd10188014;
  localparam logic signed [AngW-1:0] OneQ24    = 28'sd16777216;

  typedef logic signed [AngW-1:0] ang_t;
  typedef logic signed [25:0] q24_t;

  typedef struct packed {
    ang_t x;
    ang_t y;
    ang_t z;
  } cvec_t;

  typedef struct packed {
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] tz;
  } trans_t;

  function automatic ang_t atan_lut(input logic [4:0] i);
    unique case (i)
      5'd0:  atan_lut = 28'sd13176795;
      5'd1:  atan_lut = 28'sd7778716;
      5'd2:  atan_lut = 28'sd4110060;
      5'd3:  atan_lut = 28'sd2086331;
      5'd4:  atan_lut = 28'sd1047214;
      5'd5:  atan_lut = 28'sd524117;
      5'd6:  atan_lut = 28'sd262123;
      5'd7:  atan_lut = 28'sd131069;
      5'd8:  atan_lut = 28'sd65536;
      5'd9:  atan_lut = 28'sd32768;
      5'd10: atan_lut = 28'sd16384;
      5'd11: atan_lut = 28'sd8192;
      5'd12: atan_lut = 28'sd4096;
      5'd13: atan_lut = 28'sd2048;
      5'd14: atan_lut = 28'sd1024;
      5'd15: atan_lut = 28'sd512;
      5'd16: atan_lut = 28'sd256;
      5'd17: atan_lut = 28'sd128;
      5'd18: atan_lut = 28'sd64;
      5'd19: atan_lut = 28'sd32;
      5'd20: atan_lut = 28'sd16;
      5'd21: atan_lut = 28'sd8;
      5'd22: atan_lut = 28'sd4;
      5'd23: atan_lut = 28'sd2;
      default: atan_lut = '0;
    endcase
  endfunction

  // Rounded Q.24 product.
  function automatic q24_t mul24(input q24_t a, input q24_t b);
    logic signed [51:0] p;
    p = (52'(a) * 52'(b)) + 52'sd8388608;
    mul24 = q24_t'(p >>> 24);
  endfunction

  // Q.24 to Q1.14 with saturation.
  function automatic logic [15:0] to_q114(input logic signed [27:0] v);
    logic signed [27:0] r;
    r = (v + 28'sd512) >>> 10;
    if (r > 28'sd16384) to_q114 = 16'sd16384;
    else if (r < -28'sd16384) to_q114 = -16'sd16384;
    else to_q114 = r[15:0];
  endfunction

endpackage

### hw/rtl/eprm_cordic.sv
module eprm_cordic
  import eprm_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic signed [15:0] angle_i,
  output q24_t              sin_o,
  output q24_t              cos_o
);

  cvec_t stage_q [NumStages+1];
  logic  neg_q   [NumStages+1];
  cvec_t stage_d;
  logic  neg_d;
  ang_t  z0;

  // Fold the angle into the CORDIC range.
  always_comb begin
    z0 = ang_t'(angle_i) <<< 11;
    neg_d = 1'b0;
    if (z0 > HalfPiQ24) begin
      z0 = z0 - PiQ24;
      neg_d = 1'b1;
    end else if (z0 < -HalfPiQ24) begin
      z0 = z0 + PiQ24;
      neg_d = 1'b1;
    end
    stage_d = '{x: GainQ24, y: '0, z: z0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0] <= stage_d;
      neg_q[0]   <= neg_d;
    end
  end

  for (genvar i = 0; i < NumStages; i++) begin : g_iter
    cvec_t nxt;
    always_comb begin
      if (stage_q[i].z >= 0) begin
        nxt.x = stage_q[i].x - (stage_q[i].y >>> i);
        nxt.y = stage_q[i].y + (stage_q[i].x >>> i);
        nxt.z = stage_q[i].z - atan_lut(5'(i));
      end else begin
        nxt.x = stage_q[i].x + (stage_q[i].y >>> i);
        nxt.y = stage_q[i].y - (stage_q[i].x >>> i);
        nxt.z = stage_q[i].z + atan_lut(5'(i));
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[i+1] <= nxt;
        neg_q[i+1]   <= neg_q[i];
      end
    end
  end

  ang_t xc, yc;
  always_comb begin
    xc = stage_q[NumStages].x;
    yc = stage_q[NumStages].y;
    if (xc > OneQ24) xc = OneQ24;
    else if (xc < -OneQ24) xc = -OneQ24;
    if (yc > OneQ24) yc = OneQ24;
    else if (yc < -OneQ24) yc = -OneQ24;
    if (neg_q[NumStages]) begin
      xc = -xc;
      yc = -yc;
    end
  end

  assign cos_o = q24_t'(xc);
  assign sin_o = q24_t'(yc);

endmodule

### hw/rtl/eprm_matrix.sv
module eprm_matrix
  import eprm_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  q24_t        sr_i,
  input  q24_t        cr_i,
  input  q24_t        sp_i,
  input  q24_t        cp_i,
  input  q24_t        sy_i,
  input  q24_t        cy_i,
  output logic [143:0] m_o
);

  q24_t t_q, u_q, cycp_q, sycr_q, sysr_q, sycp_q, cycr_q, cysr_q, cpsr_q, cpcr_q;
  q24_t sr2_q, cr2_q, sp2_q;
  logic signed [27:0] e_q [9];
  logic [143:0] m_q;

  // Stage A: pairwise products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q    <= mul24(cy_i, sp_i);
      u_q    <= mul24(sy_i, sp_i);
      cycp_q <= mul24(cy_i, cp_i);
      sycr_q <= mul24(sy_i, cr_i);
      sysr_q <= mul24(sy_i, sr_i);
      sycp_q <= mul24(sy_i, cp_i);
      cycr_q <= mul24(cy_i, cr_i);
      cysr_q <= mul24(cy_i, sr_i);
      cpsr_q <= mul24(cp_i, sr_i);
      cpcr_q <= mul24(cp_i, cr_i);
      sr2_q  <= sr_i;
      cr2_q  <= cr_i;
      sp2_q  <= sp_i;
    end
  end

  // Stage B: three-factor terms and sums.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q[0] <= 28'(cycp_q);
      e_q[1] <= 28'(mul24(t_q, sr2_q)) - 28'(sycr_q);
      e_q[2] <= 28'(mul24(t_q, cr2_q)) + 28'(sysr_q);
      e_q[3] <= 28'(sycp_q);
      e_q[4] <= 28'(mul24(u_q, sr2_q)) + 28'(cycr_q);
      e_q[5] <= 28'(mul24(u_q, cr2_q)) - 28'(cysr_q);
      e_q[6] <= -28'(sp2_q);
      e_q[7] <= 28'(cpsr_q);
      e_q[8] <= 28'(cpcr_q);
    end
  end

  // Stage C: rounding to Q1.14.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) m_q[16*k +: 16] <= to_q114(e_q[k]);
    end
  end

  assign m_o = m_q;

endmodule

### hw/rtl/euler_pose_to_rotation_matrix.sv
// Euler pose to rotation matrix, Z-Y-X order.
// Slave channel s_axis_*: one request per pose, tdata packs trans_x, trans_y,
// trans_z, roll, pitch and yaw (Q16.16 translation, Q3.13 radian angles).
// Master channel m_axis_*: one result per pose, the nine Q1.14 entries of
// Rz(yaw)*Ry(pitch)*Rx(roll) followed by the unchanged translation.
// Each angle goes through its own pipelined CORDIC, one iteration per stage,
// followed by three product and rounding stages and the output register.
// Throughput is one pose per cycle while the output is not stalled; it is set by the fully pipelined CORDIC.
// The whole pipeline advances as one when the output register is empty or
// being read, so a stalled receiver freezes every stage without losing data.
// Reset clears the valid bits only; data registers are not reset.
module euler_pose_to_rotation_matrix
  import eprm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // trans_x, trans_y, trans_z, roll_angle, pitch_angle, yaw_angle from bit 0.
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // m00..m22 (16 bits each), out_x, out_y, out_z (32 bits each) from bit 0.
  output logic [239:0] m_axis_tdata
);

  localparam int Depth = NumStages + 5;

  logic en;
  logic [Depth-1:0] vld_q;
  trans_t tr_q [Depth-1];
  q24_t sr, cr, sp, cp, sy, cy;
  logic [143:0] m;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tr_q[0] <= '{tx: s_axis_tdata[31:0], ty: s_axis_tdata[63:32],
                   tz: s_axis_tdata[95:64]};
      for (int k = 1; k < Depth - 1; k++) tr_q[k] <= tr_q[k-1];
    end
  end

  eprm_cordic u_roll  (.clk_i, .en_i(en), .angle_i(s_axis_tdata[111:96]),
                       .sin_o(sr), .cos_o(cr));
  eprm_cordic u_pitch (.clk_i, .en_i(en), .angle_i(s_axis_tdata[127:112]),
                       .sin_o(sp), .cos_o(cp));
  eprm_cordic u_yaw   (.clk_i, .en_i(en), .angle_i(s_axis_tdata[143:128]),
                       .sin_o(sy), .cos_o(cy));

  eprm_matrix u_mat (.clk_i, .en_i(en), .sr_i(sr), .cr_i(cr), .sp_i(sp), .cp_i(cp),
                     .sy_i(sy), .cy_i(cy), .m_o(m));

  // The matrix output lines up with tr_q[Depth-2]; one more register at the end.
  logic [239:0] out_q;
  always_ff @(posedge clk_i) begin
    if (en) out_q <= {tr_q[Depth-2].tz, tr_q[Depth-2].ty, tr_q[Depth-2].tx, m};
  end

  assign m_axis_tvalid = vld_q[Depth-1];
  assign m_axis_tdata  = out_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("not ready while empty");
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable(vld_q)) else $error("pipeline moved while stalled");

endmodule
